// ===== src/svgva_pkg.sv =====
// Package: shared constants, types and align decode for the viewBox transform block.
package svgva_pkg;

    localparam int DIV_NUM_W = 62;
    localparam int DIV_DEN_W = 32;
    localparam int MAG_W     = 63;
    localparam int PROD_W    = 94;

    localparam logic [3:0]  ALIGN_NONE = 4'd0;
    localparam logic [3:0]  ALIGN_LAST = 4'd9;
    localparam logic [30:0] MAX31      = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        SEL_MIN,
        SEL_MID,
        SEL_MAX
    } align_sel_t;

    // Side data that rides alongside the divider pipelines
    typedef struct packed {
        logic               valid;
        logic               ident;
        logic               use_h;
        logic               neg;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } side_t;

    // Decode the x alignment of an align code
    function automatic align_sel_t x_sel(input logic [3:0] align);
        align_sel_t sel;
        case (align)
            4'd1, 4'd2, 4'd3: sel = SEL_MIN;
            4'd4, 4'd5, 4'd6: sel = SEL_MID;
            4'd7, 4'd8, 4'd9: sel = SEL_MAX;
            default:          sel = SEL_MIN;
        endcase
        return sel;
    endfunction

    // Decode the y alignment of an align code
    function automatic align_sel_t y_sel(input logic [3:0] align);
        align_sel_t sel;
        case (align)
            4'd1, 4'd4, 4'd7: sel = SEL_MIN;
            4'd2, 4'd5, 4'd8: sel = SEL_MID;
            4'd3, 4'd6, 4'd9: sel = SEL_MAX;
            default:          sel = SEL_MIN;
        endcase
        return sel;
    endfunction

endpackage

// ===== src/svg_viewbox_aspect_transform.sv =====
// Top level: viewBox-to-viewport scale and translate in fixed point.
// Fully pipelined: one item per cycle in, one result per item out. The pipeline is
// made of the two 62-stage divider pipelines (scale quotient and alignment offset run
// side by side), plus two stages ahead of them for the cross products and five after
// for the translate sum and the split 63x31 multiply.
// While a result waits under out_stall the whole pipeline holds and in_stall is raised;
// otherwise bubbles flow through and a new item is taken every cycle.
module svg_viewbox_aspect_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] view_x,
    input  logic signed [31:0] view_y,
    input  logic [30:0]        view_w,
    input  logic [30:0]        view_h,
    input  logic [30:0]        port_w,
    input  logic [30:0]        port_h,
    input  logic [3:0]         align_mode,
    input  logic               slice_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        scale_x,
    output logic [30:0]        scale_y,
    output logic signed [31:0] shift_x,
    output logic signed [31:0] shift_y,
    output logic               is_identity,
    output logic               saturated
);
    import svgva_pkg::*;

    localparam int DIV_LAT = DIV_NUM_W;

    logic en;

    // Stage 1 registers
    logic               s1_valid_reg;
    logic               s1_ident_reg;
    align_sel_t         s1_xsel_reg;
    align_sel_t         s1_ysel_reg;
    logic               s1_slice_reg;
    logic signed [31:0] s1_vx_reg;
    logic signed [31:0] s1_vy_reg;
    logic [30:0]        s1_vw_reg;
    logic [30:0]        s1_vh_reg;
    logic [30:0]        s1_pw_reg;
    logic [30:0]        s1_ph_reg;
    logic [61:0]        s1_pa_reg;
    logic [61:0]        s1_pb_reg;

    // Stage 2 logic and registers
    logic                 s2_narrower;
    logic                 s2_use_h;
    logic [62:0]          s2_dnum;
    logic                 s2_neg;
    logic [61:0]          s2_mag;
    align_sel_t           s2_sel;
    logic [DIV_DEN_W-1:0] s2_oden;
    logic [30:0]          s2_snum;
    logic [30:0]          s2_sden;
    side_t                s2_side_next;
    side_t                s2_side_reg;
    logic [DIV_NUM_W-1:0] s2_onum_reg;
    logic [DIV_DEN_W-1:0] s2_oden_reg;
    logic [DIV_NUM_W-1:0] s2_snum_reg;
    logic [DIV_DEN_W-1:0] s2_sden_reg;

    side_t                side_reg [DIV_LAT];
    logic [DIV_NUM_W-1:0] q_sc;
    logic [DIV_NUM_W-1:0] q_off;
    side_t                sd;

    // Stage 3
    logic [30:0]        s3_s;
    logic               s3_sat;
    logic signed [63:0] s3_off;
    logic signed [63:0] s3_sumx_next;
    logic signed [63:0] s3_sumy_next;
    logic               s3_valid_reg;
    logic               s3_ident_reg;
    logic [30:0]        s3_s_reg;
    logic               s3_sat_reg;
    logic signed [63:0] s3_sumx_reg;
    logic signed [63:0] s3_sumy_reg;

    // Stage 4
    logic               s4_valid_reg;
    logic               s4_ident_reg;
    logic [30:0]        s4_s_reg;
    logic               s4_sat_reg;
    logic               s4_negx_reg;
    logic               s4_negy_reg;
    logic [MAG_W-1:0]   s4_magx_reg;
    logic [MAG_W-1:0]   s4_magy_reg;

    // Stage 5
    logic               s5_valid_reg;
    logic               s5_ident_reg;
    logic [30:0]        s5_s_reg;
    logic               s5_sat_reg;
    logic               s5_negx_reg;
    logic               s5_negy_reg;
    logic [62:0]        s5_plox_reg;
    logic [61:0]        s5_phix_reg;
    logic [62:0]        s5_ploy_reg;
    logic [61:0]        s5_phiy_reg;

    // Stage 6
    logic               s6_valid_reg;
    logic               s6_ident_reg;
    logic [30:0]        s6_s_reg;
    logic               s6_sat_reg;
    logic               s6_negx_reg;
    logic               s6_negy_reg;
    logic [PROD_W-1:0]  s6_prodx_reg;
    logic [PROD_W-1:0]  s6_prody_reg;

    // Stage 7 (output)
    logic [32:0]        shx;
    logic [32:0]        shy;
    logic               out_valid_reg;
    logic [30:0]        scale_reg;
    logic signed [31:0] shift_x_reg;
    logic signed [31:0] shift_y_reg;
    logic               ident_reg;
    logic               sat_reg;

    // Scale a product down and clamp it; bit 32 flags a clamp
    function automatic logic [32:0] sat_shift(input logic [PROD_W-1:0] prod,
                                              input logic neg);
        logic        ovf;
        logic [63:0] r;
        logic [32:0] res;
        ovf = |prod[PROD_W-1:64];
        r   = 64'(prod >> FRAC_BITS);
        if (neg)
        begin
            if (ovf || (r > 64'h8000_0000))
                res = {1'b1, 32'h8000_0000};
            else
                res = {1'b0, 32'(64'd0 - r)};
        end
        else
        begin
            if (ovf || (r > 64'(MAX31)))
                res = {1'b1, 1'b0, MAX31};
            else
                res = {1'b0, r[31:0]};
        end
        return res;
    endfunction

    // Advance everything unless the result register is held
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Stage 1: decode, identity test, cross products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ident_reg <= (view_w == '0) || (view_h == '0) || (port_w == '0) ||
                            (port_h == '0) || (align_mode == ALIGN_NONE) ||
                            (align_mode > ALIGN_LAST);
            s1_xsel_reg  <= x_sel(align_mode);
            s1_ysel_reg  <= y_sel(align_mode);
            s1_slice_reg <= slice_mode;
            s1_vx_reg    <= view_x;
            s1_vy_reg    <= view_y;
            s1_vw_reg    <= view_w;
            s1_vh_reg    <= view_h;
            s1_pw_reg    <= port_w;
            s1_ph_reg    <= port_h;
            s1_pa_reg    <= 62'(view_w) * 62'(port_h);
            s1_pb_reg    <= 62'(port_w) * 62'(view_h);
        end
    end

    // Stage 2: pick the fitting axis and set up both divisions
    always_comb
    begin
        s2_narrower = (s1_pa_reg < s1_pb_reg);
        s2_use_h    = s2_narrower ^ s1_slice_reg;
        s2_dnum     = s2_use_h ? ({1'b0, s1_pa_reg} - {1'b0, s1_pb_reg})
                               : ({1'b0, s1_pb_reg} - {1'b0, s1_pa_reg});
        s2_neg      = s2_dnum[62];
        s2_mag      = s2_neg ? 62'(63'd0 - s2_dnum) : s2_dnum[61:0];
        s2_sel      = s2_use_h ? s1_xsel_reg : s1_ysel_reg;
        s2_oden     = DIV_DEN_W'(s2_use_h ? s1_ph_reg : s1_pw_reg);
        if (s2_sel == SEL_MID)
            s2_oden = s2_oden << 1;
        if (s2_sel == SEL_MIN)
            s2_mag = '0;
        s2_snum = s2_use_h ? s1_ph_reg : s1_pw_reg;
        s2_sden = s2_use_h ? s1_vh_reg : s1_vw_reg;

        s2_side_next.valid = s1_valid_reg;
        s2_side_next.ident = s1_ident_reg;
        s2_side_next.use_h = s2_use_h;
        s2_side_next.neg   = s2_neg;
        s2_side_next.vx    = s1_vx_reg;
        s2_side_next.vy    = s1_vy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_side_reg <= '0;
        else if (en)
            s2_side_reg <= s2_side_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_onum_reg <= s2_mag;
            s2_oden_reg <= s2_oden;
            s2_snum_reg <= DIV_NUM_W'(s2_snum) << FRAC_BITS;
            s2_sden_reg <= DIV_DEN_W'(s2_sden);
        end
    end

    // Divider pipelines: scale quotient and offset quotient
    svgva_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_sc (
        .clk (clk),
        .en  (en),
        .num (s2_snum_reg),
        .den (s2_sden_reg),
        .quo (q_sc)
    );

    svgva_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_off (
        .clk (clk),
        .en  (en),
        .num (s2_onum_reg),
        .den (s2_oden_reg),
        .quo (q_off)
    );

    // Delay the side data to match the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                side_reg[k] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= s2_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign sd = side_reg[DIV_LAT-1];

    // Stage 3: clamp scale, add origin and offset
    always_comb
    begin
        s3_sat = (q_sc > DIV_NUM_W'(MAX31));
        s3_s   = s3_sat ? MAX31 : q_sc[30:0];
        s3_off = sd.neg ? (64'sd0 - $signed({2'b00, q_off})) : $signed({2'b00, q_off});
        s3_sumx_next = 64'(sd.vx) + (sd.use_h ? s3_off : 64'sd0);
        s3_sumy_next = 64'(sd.vy) + (sd.use_h ? 64'sd0 : s3_off);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= sd.valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 3
            s3_ident_reg <= sd.ident;
            s3_s_reg     <= s3_s;
            s3_sat_reg   <= s3_sat;
            s3_sumx_reg  <= s3_sumx_next;
            s3_sumy_reg  <= s3_sumy_next;

            // Stage 4: translation is the negated sum, split into sign and magnitude
            s4_ident_reg <= s3_ident_reg;
            s4_s_reg     <= s3_s_reg;
            s4_sat_reg   <= s3_sat_reg;
            s4_negx_reg  <= (s3_sumx_reg > 64'sd0);
            s4_negy_reg  <= (s3_sumy_reg > 64'sd0);
            s4_magx_reg  <= s3_sumx_reg[63] ? MAG_W'(64'sd0 - s3_sumx_reg)
                                            : MAG_W'(s3_sumx_reg);
            s4_magy_reg  <= s3_sumy_reg[63] ? MAG_W'(64'sd0 - s3_sumy_reg)
                                            : MAG_W'(s3_sumy_reg);

            // Stage 5: partial products
            s5_ident_reg <= s4_ident_reg;
            s5_s_reg     <= s4_s_reg;
            s5_sat_reg   <= s4_sat_reg;
            s5_negx_reg  <= s4_negx_reg;
            s5_negy_reg  <= s4_negy_reg;
            s5_plox_reg  <= 63'(s4_magx_reg[31:0]) * 63'(s4_s_reg);
            s5_phix_reg  <= 62'(s4_magx_reg[62:32]) * 62'(s4_s_reg);
            s5_ploy_reg  <= 63'(s4_magy_reg[31:0]) * 63'(s4_s_reg);
            s5_phiy_reg  <= 62'(s4_magy_reg[62:32]) * 62'(s4_s_reg);

            // Stage 6: combine partial products
            s6_ident_reg <= s5_ident_reg;
            s6_s_reg     <= s5_s_reg;
            s6_sat_reg   <= s5_sat_reg;
            s6_negx_reg  <= s5_negx_reg;
            s6_negy_reg  <= s5_negy_reg;
            s6_prodx_reg <= {s5_phix_reg, 32'd0} + PROD_W'(s5_plox_reg);
            s6_prody_reg <= {s5_phiy_reg, 32'd0} + PROD_W'(s5_ploy_reg);
        end
    end

    // Stage 7: scale down, clamp, apply identity
    assign shx = sat_shift(s6_prodx_reg, s6_negx_reg);
    assign shy = sat_shift(s6_prody_reg, s6_negy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s6_ident_reg)
            begin
                scale_reg   <= 31'(1) << FRAC_BITS;
                shift_x_reg <= '0;
                shift_y_reg <= '0;
                ident_reg   <= 1'b1;
                sat_reg     <= 1'b0;
            end
            else
            begin
                scale_reg   <= s6_s_reg;
                shift_x_reg <= $signed(shx[31:0]);
                shift_y_reg <= $signed(shy[31:0]);
                ident_reg   <= 1'b0;
                sat_reg     <= s6_sat_reg | shx[32] | shy[32];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign scale_x     = scale_reg;
    assign scale_y     = scale_reg;
    assign shift_x     = shift_x_reg;
    assign shift_y     = shift_y_reg;
    assign is_identity = ident_reg;
    assign saturated   = sat_reg;

endmodule

// ===== src/svgva_div.sv =====
// Pipelined radix-2 restoring divider, one quotient bit per stage.
module svgva_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    genvar i;
    generate
        for (i = 0; i < NUM_W; i++)
        begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [NUM_W-1:0] nq_in;
            logic [DEN_W-1:0] den_in;
            logic [DEN_W:0]   trial;
            logic             ge;

            if (i == 0)
            begin : g_first
                assign rem_in = '0;
                assign nq_in  = num;
                assign den_in = den;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[i-1];
                assign nq_in  = nq_reg[i-1];
                assign den_in = den_reg[i-1];
            end

            // Shift in the next dividend bit and try a subtract
            assign trial = {rem_in, nq_in[NUM_W-1]};
            assign ge    = (trial >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                    nq_reg[i]  <= {nq_in[NUM_W-2:0], ge};
                    den_reg[i] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[NUM_W-1];

endmodule

// ===== src/svgva_chk.sv =====
// Checker: port-level assertions for the viewBox transform block, with its bind.
module svgva_chk #(
    parameter int FRAC_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [30:0]        scale_x,
    input logic [30:0]        scale_y,
    input logic signed [31:0] shift_x,
    input logic signed [31:0] shift_y,
    input logic               is_identity,
    input logic               saturated
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(scale_x) && $stable(shift_x) &&
                                   $stable(shift_y))
        else $error("stalled result changed");

    // Keep the scale uniform
    a_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> scale_x == scale_y)
        else $error("scale not uniform");

    // Identity results carry unit scale, no shift and no clamp
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_identity |-> scale_x == (31'(1) << FRAC_BITS) &&
                                     shift_x == 32'sd0 && shift_y == 32'sd0 && !saturated)
        else $error("bad identity result");

    // Stall the input while a result is held
    a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output held");

endmodule

bind svg_viewbox_aspect_transform svgva_chk #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);
